@@ rtl/core/ps2_keyboard_receiver_core_defines.svh @@
// assertion macros for the ps2 keyboard receiver core
`ifndef PS2_KEYBOARD_RECEIVER_CORE_DEFINES_SVH
`define PS2_KEYBOARD_RECEIVER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define PS2KR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ps2kr assertion failed");
// next-cycle implication, checked out of reset
`define PS2KR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ps2kr assertion failed");
`else
`define PS2KR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PS2KR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/ps2kr_pkg.sv @@
// shared types, constants and scan code table for the ps2 keyboard receiver
package ps2kr_pkg;

	localparam int unsigned FRAME_QUEUE_DEPTH = 2;

	localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
	localparam logic [15:0] IDLE_MAX       = 16'hFFFF;
	localparam logic [7:0]  BREAK_CODE     = 8'hF0;
	localparam logic [7:0]  ENTER_CODE     = 8'h5A;
	localparam logic [7:0]  BACKSPACE_CODE = 8'h66;
	localparam logic [6:0]  CHAR_NONE      = 7'd0;
	localparam logic [6:0]  CHAR_ENTER     = 7'd1;
	localparam logic [6:0]  CHAR_BACKSPACE = 7'd2;

	// frame bit positions
	localparam logic [3:0] POS_WAIT   = 4'd0;
	localparam logic [3:0] POS_DATA_Z = 4'd8;
	localparam logic [3:0] POS_PARITY = 4'd9;
	localparam logic [3:0] POS_STOP   = 4'd10;

	typedef struct packed {
		logic ps2_clock;
		logic ps2_data;
	} sample_t;

	typedef struct packed {
		logic [7:0] scan_code;
		logic [6:0] char_code;
		logic       released;
		logic       break_prefix;
		logic       stop_ok;
		logic       parity_ok;
	} result_t;

	// raw frame handed from the receiver to the decoder
	typedef struct packed {
		logic [7:0] code;
		logic       parity_bit;
		logic       stop_bit;
	} frame_t;

	function automatic logic [6:0] key_to_ascii(input logic [7:0] code);
		logic [6:0] ch;
		unique case (code)
			8'h1C: ch = 7'h61;
			8'h32: ch = 7'h62;
			8'h21: ch = 7'h63;
			8'h23: ch = 7'h64;
			8'h24: ch = 7'h65;
			8'h2B: ch = 7'h66;
			8'h34: ch = 7'h67;
			8'h33: ch = 7'h68;
			8'h43: ch = 7'h69;
			8'h3B: ch = 7'h6A;
			8'h42: ch = 7'h6B;
			8'h4B: ch = 7'h6C;
			8'h3A: ch = 7'h6D;
			8'h31: ch = 7'h6E;
			8'h44: ch = 7'h6F;
			8'h4D: ch = 7'h70;
			8'h15: ch = 7'h71;
			8'h2D: ch = 7'h72;
			8'h1B: ch = 7'h73;
			8'h2C: ch = 7'h74;
			8'h3C: ch = 7'h75;
			8'h2A: ch = 7'h76;
			8'h1D: ch = 7'h77;
			8'h22: ch = 7'h78;
			8'h35: ch = 7'h79;
			8'h1A: ch = 7'h7A;
			8'h29: ch = 7'h20;
			8'h45: ch = 7'h30;
			8'h16: ch = 7'h31;
			8'h1E: ch = 7'h32;
			8'h26: ch = 7'h33;
			8'h25: ch = 7'h34;
			8'h2E: ch = 7'h35;
			8'h36: ch = 7'h36;
			8'h3D: ch = 7'h37;
			8'h3E: ch = 7'h38;
			8'h46: ch = 7'h39;
			8'h0E: ch = 7'h27;
			8'h4E: ch = 7'h2D;
			8'h55: ch = 7'h3D;
			8'h5D: ch = 7'h5C;
			ENTER_CODE:     ch = CHAR_ENTER;
			BACKSPACE_CODE: ch = CHAR_BACKSPACE;
			default:        ch = CHAR_NONE;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/core/ps2kr_frame_rx.sv @@
// front end: edge detect, frame bit counter, shifter and idle timeout
`include "ps2_keyboard_receiver_core_defines.svh"
module ps2kr_frame_rx (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  ps2kr_pkg::sample_t sample,
	input  logic [15:0]        timeout,
	output logic               frame_valid,
	output ps2kr_pkg::frame_t  frame
);

	logic        clock_prev_q;
	logic [3:0]  bit_pos_q, bit_pos_d;
	logic [7:0]  shift_q, shift_d;
	logic        parity_q, parity_d;
	logic [15:0] idle_q, idle_d, idle_inc;
	logic        fall;

	assign fall     = clock_prev_q & ~sample.ps2_clock;
	assign idle_inc = (idle_q != ps2kr_pkg::IDLE_MAX) ? idle_q + 16'd1 : idle_q;

	always_comb begin
		bit_pos_d   = bit_pos_q;
		shift_d     = shift_q;
		parity_d    = parity_q;
		idle_d      = idle_q;
		frame_valid = 1'b0;
		if (fall) begin
			idle_d = '0;
			if (bit_pos_q == ps2kr_pkg::POS_WAIT) begin
				if (!sample.ps2_data) begin
					bit_pos_d = 4'd1;
					shift_d   = '0;
					parity_d  = 1'b0;
				end
			end else if (bit_pos_q <= ps2kr_pkg::POS_DATA_Z) begin
				shift_d   = {sample.ps2_data, shift_q[7:1]};
				bit_pos_d = bit_pos_q + 4'd1;
			end else if (bit_pos_q == ps2kr_pkg::POS_PARITY) begin
				parity_d  = sample.ps2_data;
				bit_pos_d = ps2kr_pkg::POS_STOP;
			end else if (bit_pos_q == ps2kr_pkg::POS_STOP) begin
				frame_valid = accept;
				bit_pos_d   = ps2kr_pkg::POS_WAIT;
			end else begin
				bit_pos_d = ps2kr_pkg::POS_WAIT;
			end
		end else if (bit_pos_q != ps2kr_pkg::POS_WAIT) begin
			idle_d = idle_inc;
			if (idle_inc >= timeout) begin
				bit_pos_d = ps2kr_pkg::POS_WAIT;
				idle_d    = '0;
			end
		end else begin
			idle_d = '0;
		end
	end

	assign frame.code       = shift_q;
	assign frame.parity_bit = parity_q;
	assign frame.stop_bit   = sample.ps2_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_prev_q <= 1'b1;
			bit_pos_q    <= ps2kr_pkg::POS_WAIT;
			shift_q      <= '0;
			parity_q     <= 1'b0;
			idle_q       <= '0;
		end else if (accept) begin
			clock_prev_q <= sample.ps2_clock;
			bit_pos_q    <= bit_pos_d;
			shift_q      <= shift_d;
			parity_q     <= parity_d;
			idle_q       <= idle_d;
		end
	end

	`PS2KR_ASSERT_IMPLIES(a_frame_on_fall, clk, arst_n, frame_valid, accept && clock_prev_q && !sample.ps2_clock)
	`PS2KR_ASSERT_NEXT(a_wait_after_frame, clk, arst_n, frame_valid, bit_pos_q == ps2kr_pkg::POS_WAIT)

endmodule

@@ rtl/core/ps2kr_frame_queue.sv @@
// small queue of raw frames between receiver and decoder
`include "ps2_keyboard_receiver_core_defines.svh"
module ps2kr_frame_queue #(
	parameter int unsigned DEPTH = ps2kr_pkg::FRAME_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ps2kr_pkg::frame_t wdata,
	input  logic              pop,
	output ps2kr_pkg::frame_t rdata,
	output logic              empty,
	output logic              full
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
	localparam logic [PW-1:0] PTR_LAST   = PW'(DEPTH - 1);

	ps2kr_pkg::frame_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == COUNT_FULL);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`PS2KR_ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= COUNT_FULL)

endmodule

@@ rtl/core/ps2kr_decode.sv @@
// back end: break prefix tracking, ascii mapping and result register
`include "ps2_keyboard_receiver_core_defines.svh"
module ps2kr_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_avail,
	input  ps2kr_pkg::frame_t  frame,
	output logic               frame_take,
	input  logic               pop,
	output logic               empty,
	output ps2kr_pkg::result_t result
);

	logic               out_valid_q;
	logic               break_pending_q, break_pending_d;
	ps2kr_pkg::result_t result_q, result_d;
	logic               is_break;

	assign frame_take = frame_avail && (!out_valid_q || pop);
	assign is_break   = (frame.code == ps2kr_pkg::BREAK_CODE);

	always_comb begin
		break_pending_d       = break_pending_q;
		result_d.scan_code    = frame.code;
		result_d.char_code    = ps2kr_pkg::CHAR_NONE;
		result_d.released     = break_pending_q;
		result_d.break_prefix = is_break;
		result_d.stop_ok      = frame.stop_bit;
		result_d.parity_ok    = ^{frame.parity_bit, frame.code};
		if (frame.stop_bit) begin
			if (is_break) begin
				break_pending_d   = 1'b1;
				result_d.released = 1'b0;
			end else begin
				if (!break_pending_q) begin
					result_d.char_code = ps2kr_pkg::key_to_ascii(frame.code);
				end
				break_pending_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			break_pending_q <= 1'b0;
		end else begin
			if (frame_take) begin
				out_valid_q     <= 1'b1;
				break_pending_q <= break_pending_d;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign result = result_q;

	`PS2KR_ASSERT_IMPLIES(a_prefix_not_released, clk, arst_n, out_valid_q && result_q.break_prefix && result_q.stop_ok, !result_q.released && result_q.char_code == ps2kr_pkg::CHAR_NONE)
	`PS2KR_ASSERT_IMPLIES(a_bad_stop_no_char, clk, arst_n, out_valid_q && !result_q.stop_ok, result_q.char_code == ps2kr_pkg::CHAR_NONE)

endmodule

@@ rtl/core/ps2_keyboard_receiver_core.sv @@
// top level of the ps2 keyboard receiver core
// takes one synchronized sample of the ps2 clock and data lines per cycle
// and gives one result transaction per received frame (start, eight data
// bits lsb first, parity, stop). a sample transaction is accepted every
// cycle that full is low, back to back; full rises only when the frame
// queue is full because results are not being popped, and it stays low
// as long as the result side keeps up. a result reaches the result ports
// from the sample that carries the stop bit through the frame queue and
// then the decoder's result register. the receiver front end owns
// edge detection, bit counting and the idle timeout; the decoder owns the
// 0xf0 break prefix tracking and the scan code to ascii table. the timeout
// register resets to 1000 and is written through the cfg channel, which is
// always ready; write it only while no frame is in flight.
module ps2_keyboard_receiver_core #(
	parameter int unsigned QUEUE_DEPTH = ps2kr_pkg::FRAME_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample side
	input  logic               push,
	output logic               full,
	input  ps2kr_pkg::sample_t sample,
	// result side
	output logic               empty,
	input  logic               pop,
	output ps2kr_pkg::result_t result,
	// timeout register write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	logic              accept;
	logic [15:0]       timeout_q;
	logic              frame_valid;
	ps2kr_pkg::frame_t frame_rx;
	ps2kr_pkg::frame_t frame_head;
	logic              queue_empty;
	logic              queue_full;
	logic              frame_take;

	// config is a plain register, never back-pressured
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ps2kr_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	// a sample can only end one frame, so one free slot is enough
	assign full   = queue_full;
	assign accept = push && !full;

	ps2kr_frame_rx u_frame_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample      (sample),
		.timeout     (timeout_q),
		.frame_valid (frame_valid),
		.frame       (frame_rx)
	);

	// decouples the receiver from a stalled result side
	ps2kr_frame_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_frame_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (frame_valid),
		.wdata  (frame_rx),
		.pop    (frame_take),
		.rdata  (frame_head),
		.empty  (queue_empty),
		.full   (queue_full)
	);

	// decoder pulls a frame whenever its result register is free or draining
	ps2kr_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_avail (!queue_empty),
		.frame       (frame_head),
		.frame_take  (frame_take),
		.pop         (pop),
		.empty       (empty),
		.result      (result)
	);

endmodule

@@ sim/ps2kr_scoreboard.sv @@
// scoreboard for the ps2 keyboard receiver: line decode prediction and result compare
module ps2kr_scoreboard
	import ps2kr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  sample_t     sample,
	input  logic        empty,
	input  logic        pop,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic        clock_last;
	logic [3:0]  frame_pos;
	logic [7:0]  code_shift;
	logic        parity_seen;
	logic        release_armed;
	logic [15:0] quiet_count;
	logic [15:0] timeout_limit;
	result_t     results_due[$];

	function automatic logic [6:0] ascii_of_key(input logic [7:0] code);
		logic [7:0] ch;
		case (code)
			8'h1C: ch = "a";
			8'h32: ch = "b";
			8'h21: ch = "c";
			8'h23: ch = "d";
			8'h24: ch = "e";
			8'h2B: ch = "f";
			8'h34: ch = "g";
			8'h33: ch = "h";
			8'h43: ch = "i";
			8'h3B: ch = "j";
			8'h42: ch = "k";
			8'h4B: ch = "l";
			8'h3A: ch = "m";
			8'h31: ch = "n";
			8'h44: ch = "o";
			8'h4D: ch = "p";
			8'h15: ch = "q";
			8'h2D: ch = "r";
			8'h1B: ch = "s";
			8'h2C: ch = "t";
			8'h3C: ch = "u";
			8'h2A: ch = "v";
			8'h1D: ch = "w";
			8'h22: ch = "x";
			8'h35: ch = "y";
			8'h1A: ch = "z";
			8'h29: ch = " ";
			8'h45: ch = "0";
			8'h16: ch = "1";
			8'h1E: ch = "2";
			8'h26: ch = "3";
			8'h25: ch = "4";
			8'h2E: ch = "5";
			8'h36: ch = "6";
			8'h3D: ch = "7";
			8'h3E: ch = "8";
			8'h46: ch = "9";
			8'h0E: ch = "'";
			8'h4E: ch = "-";
			8'h55: ch = "=";
			8'h5D: ch = "\\";
			ENTER_CODE:     ch = {1'b0, CHAR_ENTER};
			BACKSPACE_CODE: ch = {1'b0, CHAR_BACKSPACE};
			default:        ch = {1'b0, CHAR_NONE};
		endcase
		return ch[6:0];
	endfunction

	// advance the line decoder by one sample, returns 1 when a frame completes
	function automatic bit decode_sample(input sample_t s, output result_t r);
		logic fall;
		bit   done;
		fall = clock_last && !s.ps2_clock;
		done = 1'b0;
		r = '0;
		clock_last = s.ps2_clock;
		if (fall) begin
			quiet_count = '0;
			if (frame_pos == POS_WAIT) begin
				// a high start bit is ignored
				if (!s.ps2_data) begin
					frame_pos = POS_WAIT + 4'd1;
					code_shift = '0;
					parity_seen = 1'b0;
				end
			end else if (frame_pos <= POS_DATA_Z) begin
				code_shift = {s.ps2_data, code_shift[7:1]};
				frame_pos = frame_pos + 4'd1;
			end else if (frame_pos == POS_PARITY) begin
				parity_seen = s.ps2_data;
				frame_pos = POS_STOP;
			end else if (frame_pos == POS_STOP) begin
				r.scan_code    = code_shift;
				r.char_code    = CHAR_NONE;
				r.released     = release_armed;
				r.break_prefix = (code_shift == BREAK_CODE);
				r.stop_ok      = s.ps2_data;
				r.parity_ok    = ^{parity_seen, code_shift};
				// bad stop bit leaves the break tracking alone
				if (s.ps2_data) begin
					if (r.break_prefix) begin
						release_armed = 1'b1;
						r.released = 1'b0;
					end else begin
						if (!release_armed)
							r.char_code = ascii_of_key(code_shift);
						release_armed = 1'b0;
					end
				end
				done = 1'b1;
				frame_pos = POS_WAIT;
			end else begin
				frame_pos = POS_WAIT;
			end
		end else if (frame_pos != POS_WAIT) begin
			if (quiet_count != IDLE_MAX)
				quiet_count = quiet_count + 16'd1;
			if (quiet_count >= timeout_limit) begin
				frame_pos = POS_WAIT;
				quiet_count = '0;
			end
		end else begin
			quiet_count = '0;
		end
		return done;
	endfunction

	task automatic report_miss(input string what, input result_t want);
		if (mismatches < 10)
			$display("%0t %s: want code=%h char=%h rel=%b brk=%b stop=%b par=%b, got code=%h char=%h rel=%b brk=%b stop=%b par=%b",
				$time, what, want.scan_code, want.char_code, want.released,
				want.break_prefix, want.stop_ok, want.parity_ok,
				result.scan_code, result.char_code, result.released,
				result.break_prefix, result.stop_ok, result.parity_ok);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			clock_last    = 1'b1;
			frame_pos     = POS_WAIT;
			code_shift    = '0;
			parity_seen   = 1'b0;
			release_armed = 1'b0;
			quiet_count   = '0;
			timeout_limit = TIMEOUT_RESET;
			results_due.delete();
			mismatches    = 0;
		end else begin
			// compare before predicting so a stray result never meets a fresh expectation
			if (pop && !empty) begin
				if (results_due.size() == 0) begin
					report_miss("unexpected result", '0);
				end else begin
					want = results_due.pop_front();
					if (result.scan_code !== want.scan_code ||
						result.char_code !== want.char_code ||
						result.released !== want.released ||
						result.break_prefix !== want.break_prefix ||
						result.stop_ok !== want.stop_ok ||
						result.parity_ok !== want.parity_ok)
						report_miss("result mismatch", want);
				end
			end
			if (push && !full) begin
				if (decode_sample(sample, fresh))
					results_due.push_back(fresh);
			end
			if (cfg_valid && cfg_ready)
				timeout_limit = cfg_data;
		end
		pending = results_due.size();
	end

endmodule

@@ sim/testbench.sv @@
// top of the ps2 keyboard receiver testbench: clock, reset, line stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ps2kr_pkg::*;

	// result reaches the ports through the frame queue and the result register, keep a margin
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_KEYS = 43;
	// short timeout used to walk the drop boundary
	localparam logic [15:0] BOUND_TICKS = 16'd16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	sample_t     sample;
	logic        empty;
	logic        pop;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	int          mismatches;
	int          pending;

	// when set, neither side inserts idle cycles
	bit calm;
	int samples_sent;

	// every code that maps to a character, enter and backspace included
	logic [7:0] key_codes [0:NUM_KEYS-1] = '{
		8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43, 8'h3B,
		8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C,
		8'h3C, 8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A, 8'h29, 8'h45, 8'h16, 8'h1E,
		8'h26, 8'h25, 8'h2E, 8'h36, 8'h3D, 8'h3E, 8'h46, 8'h0E, 8'h4E, 8'h55,
		8'h5D, ENTER_CODE, BACKSPACE_CODE
	};

	ps2_keyboard_receiver_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	ps2kr_scoreboard score (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#500_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stall before each pop transaction, none while calm
	initial begin
		int stall;
		pop <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// one sample transaction, with a random gap in front of it unless calm;
	// push is left high on return so back to back samples never toggle it
	task automatic put_sample(input logic lvl, input logic dat);
		int      gap;
		sample_t s;
		gap = calm ? 0 : $urandom_range(0, 6);
		s.ps2_clock = lvl;
		s.ps2_data  = dat;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push   <= 1'b1;
		sample <= s;
		do @(posedge clk); while (full);
		samples_sent++;
	endtask

	// one bit cell: hi samples with the clock high, then the falling edge
	// carrying the bit, then lo-1 more low samples; data is noise off the edge
	task automatic send_bit(input logic b, input int hi, input int lo);
		repeat (hi) put_sample(1'b1, 1'($urandom_range(0, 1)));
		put_sample(1'b0, b);
		repeat (lo - 1) put_sample(1'b0, 1'($urandom_range(0, 1)));
	endtask

	// whole frame: start, eight data bits lsb first, parity, stop
	task automatic send_frame(input logic [7:0] code, input bit parity_good,
		input logic stop_bit, input int hi_max, input int lo_max);
		logic [10:0] bits;
		bits = {stop_bit, parity_good ? ~^code : ^code, code, 1'b0};
		for (int k = 0; k < 11; k++)
			send_bit(bits[k], $urandom_range(1, hi_max), $urandom_range(1, lo_max));
	endtask

	// wait until every predicted result has been popped, plus pipeline margin
	task automatic drain_results();
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// timeout register update, only with the receiver between frames
	task automatic write_timeout(input logic [15:0] value);
		// falling edges with data high close any open frame within ten bits
		// and are ignored once the receiver waits for a start bit
		repeat (10) begin
			put_sample(1'b1, 1'b1);
			put_sample(1'b0, 1'b1);
		end
		put_sample(1'b1, 1'b1);
		// sender holds off until the result side has caught up
		push <= 1'b0;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mix of clean key frames, break sequences, raw bytes, cut frames and
	// line noise; hi_max and lo_max set how far bit cells stretch, which
	// against the current timeout decides how often frames get dropped
	task automatic random_traffic(input int quota, input int hi_max, input int lo_max);
		int         stop_at;
		int         pick;
		logic [7:0] code;
		stop_at = samples_sent + quota;
		while (samples_sent < stop_at) begin
			calm = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 99);
			code = key_codes[$urandom_range(0, NUM_KEYS - 1)];
			if (pick < 45) begin
				send_frame(code, $urandom_range(0, 11) != 0, $urandom_range(0, 11) != 0,
					hi_max, lo_max);
			end else if (pick < 65) begin
				// key release: break prefix then the key
				send_frame(BREAK_CODE, $urandom_range(0, 11) != 0,
					$urandom_range(0, 11) != 0, hi_max, lo_max);
				send_frame(code, $urandom_range(0, 11) != 0, $urandom_range(0, 11) != 0,
					hi_max, lo_max);
			end else if (pick < 80) begin
				send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
					$urandom_range(0, 5) != 0, hi_max, lo_max);
			end else if (pick < 90) begin
				// cut frame: a few random bit cells
				repeat ($urandom_range(1, 10))
					send_bit(1'($urandom_range(0, 1)), $urandom_range(1, hi_max),
						$urandom_range(1, lo_max));
			end else begin
				repeat ($urandom_range(1, 8))
					put_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		sample    <= '{ps2_clock: 1'b1, ps2_data: 1'b1};
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		calm = 1'b0;
		samples_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, timeout at its reset value
		// high start bits are ignored
		send_bit(1'b1, 1, 1);
		send_bit(1'b1, 2, 2);
		// data extremes and the special keys
		send_frame(8'h00, 1'b1, 1'b1, 2, 2);
		send_frame(8'hFF, 1'b1, 1'b1, 2, 2);
		send_frame(8'h1C, 1'b1, 1'b1, 2, 2);
		send_frame(ENTER_CODE, 1'b1, 1'b1, 2, 2);
		send_frame(BACKSPACE_CODE, 1'b1, 1'b1, 2, 2);
		// parity error is only reported
		send_frame(8'h5D, 1'b0, 1'b1, 2, 2);
		// release of a key, then a doubled break prefix
		send_frame(BREAK_CODE, 1'b1, 1'b1, 2, 2);
		send_frame(8'h1C, 1'b1, 1'b1, 2, 2);
		send_frame(BREAK_CODE, 1'b1, 1'b1, 2, 2);
		send_frame(BREAK_CODE, 1'b1, 1'b1, 2, 2);
		send_frame(8'h29, 1'b1, 1'b1, 2, 2);
		// bad stop bit on a key, on a break prefix, and inside a release
		send_frame(8'h1C, 1'b1, 1'b0, 2, 2);
		send_frame(BREAK_CODE, 1'b1, 1'b0, 2, 2);
		send_frame(8'h16, 1'b1, 1'b1, 2, 2);
		send_frame(BREAK_CODE, 1'b1, 1'b1, 2, 2);
		send_frame(8'h24, 1'b0, 1'b0, 2, 2);
		send_frame(8'h24, 1'b1, 1'b1, 2, 2);

		// timeout boundary at a short limit: one short of the limit keeps the frame
		write_timeout(BOUND_TICKS);
		calm = 1'b1;
		send_bit(1'b0, 1, 1);
		send_bit(1'b1, 1, 1);
		send_bit(1'b0, 1, 1);
		repeat (int'(BOUND_TICKS) - 1) put_sample(1'b1, 1'($urandom_range(0, 1)));
		send_bit(1'b1, 0, 1);
		for (int k = 3; k < 9; k++)
			send_bit(1'($urandom_range(0, 1)), 1, 1);
		send_bit(1'($urandom_range(0, 1)), 1, 1);
		send_bit(1'b1, 1, 1);
		// reaching the limit drops the frame, the next one starts clean
		send_bit(1'b0, 1, 1);
		send_bit(1'b1, 1, 1);
		send_bit(1'b1, 1, 1);
		repeat (int'(BOUND_TICKS)) put_sample(1'b1, 1'($urandom_range(0, 1)));
		calm = 1'b0;
		send_frame(8'h4E, 1'b1, 1'b1, 2, 2);

		random_traffic(50, 3, 3);

		// shortest timeout: no frame can ever finish
		write_timeout(16'd1);
		random_traffic(25, 2, 2);

		// tightest timeout that still lets back to back bit cells through
		write_timeout(16'd2);
		random_traffic(50, 1, 1);

		// cells stretch right up to and past the limit
		write_timeout(16'd7);
		random_traffic(50, 4, 4);

		write_timeout(16'($urandom_range(3, 12)));
		random_traffic(40, 5, 5);

		// longest timeout: stretched cells never drop a frame
		write_timeout(16'hFFFF);
		send_frame(8'h66, 1'b1, 1'b1, 3, 3);
		random_traffic(40, 6, 6);

		// back to the reset value
		write_timeout(TIMEOUT_RESET);
		random_traffic(25, 3, 3);

		push <= 1'b0;
		drain_results();
		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
